// ===== rtl/vector_to_pitch_yaw_unit_defines.svh =====
// Assertion macros shared by the vector_to_pitch_yaw_unit RTL.
`ifndef VECTOR_TO_PITCH_YAW_UNIT_DEFINES_SVH
`define VECTOR_TO_PITCH_YAW_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define V2PY_ASSERT_IMP(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define V2PY_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/v2py_pkg.sv =====
// Constants and arctangent table shared by the pitch/yaw CORDIC datapath.
package v2py_pkg;

    localparam int GUARD_BITS    = 26;
    localparam int DP_HEADROOM   = 4;
    localparam int ANGLE_FRAC    = 20;
    localparam int ANGLE_W       = 31;
    localparam int CORDIC_STAGES = 24;
    localparam int GAIN_W        = 31;
    localparam int GAIN_SHIFT    = 4;
    localparam int TRUNC_BIAS    = 128;
    localparam int DEG_W         = 9;
    localparam int DEG_360       = 360;

    localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;

    localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
    localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
    localparam logic [DEG_W-1:0] DEG_359 = 9'd359;

    localparam logic signed [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(180 * (2 ** ANGLE_FRAC));

    // atan(2^-i) in degrees, 20 fractional bits, rounded to nearest.
    localparam logic [ANGLE_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
        31'd47185920, 31'd27855475, 31'd14718068, 31'd7471121,
        31'd3750058,  31'd1876857,  31'd938658,   31'd469357,
        31'd234682,   31'd117342,   31'd58671,    31'd29335,
        31'd14668,    31'd7334,     31'd3667,     31'd1833,
        31'd917,      31'd458,      31'd229,      31'd115,
        31'd57,       31'd29,       31'd14,       31'd7
    };

endpackage

// ===== rtl/v2py_vec_if.sv =====
// Valid/ready channel that carries one input vector item.
interface v2py_vec_if #(
    parameter int WIDTH = 24
) ();

    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] x_component;
    logic signed [WIDTH-1:0] y_component;
    logic signed [WIDTH-1:0] z_component;

    modport source (
        output valid,
        output x_component,
        output y_component,
        output z_component,
        input  ready
    );

    modport sink (
        input  valid,
        input  x_component,
        input  y_component,
        input  z_component,
        output ready
    );

endinterface

// ===== rtl/v2py_ang_if.sv =====
// Valid/ready channel that carries one pitch/yaw result item.
interface v2py_ang_if
    import v2py_pkg::*;
();

    logic             valid;
    logic             ready;
    logic [DEG_W-1:0] pitch_deg;
    logic [DEG_W-1:0] yaw_deg;

    modport source (
        output valid,
        output pitch_deg,
        output yaw_deg,
        input  ready
    );

    modport sink (
        input  valid,
        input  pitch_deg,
        input  yaw_deg,
        output ready
    );

endinterface

// ===== rtl/vector_to_pitch_yaw_unit.sv =====
// Top level: vector to whole-degree pitch and yaw through two chained CORDIC passes.
//
//   Channel  Direction  Payload                                  Handshake
//   vec      in         x_component, y_component, z_component    valid / ready
//   ang      out        pitch_deg, yaw_deg                       valid / ready
//
// One item enters per cycle while the row is not stalled; each result passes through
// the 49 item registers: the entry cell, 23 yaw cells, the join cell with the
// last yaw iteration, 23 pitch cells and the exit cell with the last pitch iteration.
// Every cell holds its own item, so a stall on ang backs up one cell at a time and
// empty cells keep taking items; vec.ready falls only when the whole row is full.
// Reset clears only the valid bit of each cell; the datapath registers keep no reset.
module vector_to_pitch_yaw_unit
    import v2py_pkg::*;
#(
    parameter int COMPONENT_WIDTH = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    v2py_vec_if.sink    vec,
    v2py_ang_if.source  ang
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int DW = CW + GUARD_BITS + DP_HEADROOM;
    localparam int PW = CW + GAIN_W;
    localparam int KY = PW + 3;
    localparam int KP = ANGLE_W + 2;
    localparam int NC = CORDIC_STAGES - 1;

    logic                      yaw_valid [0:NC];
    logic                      yaw_ready [0:NC];
    logic signed [DW-1:0]      yaw_x     [0:NC];
    logic signed [DW-1:0]      yaw_y     [0:NC];
    logic signed [ANGLE_W-1:0] yaw_a     [0:NC];
    logic [KY-1:0]             yaw_k     [0:NC];

    logic                      pit_valid [0:NC];
    logic                      pit_ready [0:NC];
    logic signed [DW-1:0]      pit_x     [0:NC];
    logic signed [DW-1:0]      pit_y     [0:NC];
    logic signed [ANGLE_W-1:0] pit_a     [0:NC];
    logic [KP-1:0]             pit_k     [0:NC];

    v2py_prep #(
        .CW (CW)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .vec      (vec),
        .dn_valid (yaw_valid[0]),
        .dn_ready (yaw_ready[0]),
        .dn_x     (yaw_x[0]),
        .dn_y     (yaw_y[0]),
        .dn_ang   (yaw_a[0]),
        .dn_keep  (yaw_k[0])
    );

    for (genvar i = 0; i < NC; i++)
    begin : g_yaw
        v2py_cell #(
            .DW    (DW),
            .KW    (KY),
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (yaw_valid[i]),
            .up_ready (yaw_ready[i]),
            .up_x     (yaw_x[i]),
            .up_y     (yaw_y[i]),
            .up_ang   (yaw_a[i]),
            .up_keep  (yaw_k[i]),
            .dn_valid (yaw_valid[i+1]),
            .dn_ready (yaw_ready[i+1]),
            .dn_x     (yaw_x[i+1]),
            .dn_y     (yaw_y[i+1]),
            .dn_ang   (yaw_a[i+1]),
            .dn_keep  (yaw_k[i+1])
        );
    end

    v2py_join #(
        .CW (CW)
    ) u_join (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (yaw_valid[NC]),
        .up_ready (yaw_ready[NC]),
        .up_x     (yaw_x[NC]),
        .up_y     (yaw_y[NC]),
        .up_ang   (yaw_a[NC]),
        .up_keep  (yaw_k[NC]),
        .dn_valid (pit_valid[0]),
        .dn_ready (pit_ready[0]),
        .dn_x     (pit_x[0]),
        .dn_y     (pit_y[0]),
        .dn_keep  (pit_k[0])
    );

    // The pitch pass accumulates its angle from zero.
    assign pit_a[0] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_pitch
        v2py_cell #(
            .DW    (DW),
            .KW    (KP),
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (pit_valid[i]),
            .up_ready (pit_ready[i]),
            .up_x     (pit_x[i]),
            .up_y     (pit_y[i]),
            .up_ang   (pit_a[i]),
            .up_keep  (pit_k[i]),
            .dn_valid (pit_valid[i+1]),
            .dn_ready (pit_ready[i+1]),
            .dn_x     (pit_x[i+1]),
            .dn_y     (pit_y[i+1]),
            .dn_ang   (pit_a[i+1]),
            .dn_keep  (pit_k[i+1])
        );
    end

    v2py_deg #(
        .CW (CW)
    ) u_deg (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pit_valid[NC]),
        .up_ready (pit_ready[NC]),
        .up_x     (pit_x[NC]),
        .up_y     (pit_y[NC]),
        .up_ang   (pit_a[NC]),
        .up_keep  (pit_k[NC]),
        .ang      (ang)
    );

endmodule

// ===== rtl/v2py_cell.sv =====
// One vectoring CORDIC iteration with its own item register and local stall.
`include "vector_to_pitch_yaw_unit_defines.svh"

module v2py_cell
    import v2py_pkg::*;
#(
    parameter int DW    = 54,
    parameter int KW    = 58,
    parameter int STAGE = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic signed [DW-1:0]      up_x,
    input  logic signed [DW-1:0]      up_y,
    input  logic signed [ANGLE_W-1:0] up_ang,
    input  logic [KW-1:0]             up_keep,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output logic signed [DW-1:0]      dn_x,
    output logic signed [DW-1:0]      dn_y,
    output logic signed [ANGLE_W-1:0] dn_ang,
    output logic [KW-1:0]             dn_keep
);

    logic                      take;
    logic                      rot_pos;
    logic signed [DW-1:0]      xs;
    logic signed [DW-1:0]      ys;
    logic                      valid_reg;
    logic                      valid_next;
    logic signed [DW-1:0]      x_reg;
    logic signed [DW-1:0]      x_next;
    logic signed [DW-1:0]      y_reg;
    logic signed [DW-1:0]      y_next;
    logic signed [ANGLE_W-1:0] ang_reg;
    logic signed [ANGLE_W-1:0] ang_next;
    logic [KW-1:0]             keep_reg;

    // The cell takes a new item whenever it is empty or its item leaves.
    assign take     = !valid_reg || dn_ready;
    assign up_ready = take;

    always_comb
    begin
        xs      = up_x >>> STAGE;
        ys      = up_y >>> STAGE;
        rot_pos = !up_y[DW-1];
        if (rot_pos)
        begin
            x_next   = up_x + ys;
            y_next   = up_y - xs;
            ang_next = up_ang + ATAN_TAB[STAGE];
        end
        else
        begin
            x_next   = up_x - ys;
            y_next   = up_y + xs;
            ang_next = up_ang - ATAN_TAB[STAGE];
        end
        valid_next = take ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            keep_reg <= up_keep;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_ang   = ang_reg;
    assign dn_keep  = keep_reg;

    // x starts non-negative and only grows, so a set sign bit means overflow.
    `V2PY_ASSERT_IMP(a_cell_x_sign, valid_reg, !x_reg[DW-1], "cell x went negative")

endmodule

// ===== rtl/v2py_prep.sv =====
// Entry cell: folds x into the right half plane, scales, and multiplies z by the gain.
module v2py_prep
    import v2py_pkg::*;
#(
    parameter int CW = 24,
    localparam int DW = CW + GUARD_BITS + DP_HEADROOM,
    localparam int PW = CW + GAIN_W,
    localparam int KW = PW + 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    v2py_vec_if.sink                  vec,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output logic signed [DW-1:0]      dn_x,
    output logic signed [DW-1:0]      dn_y,
    output logic signed [ANGLE_W-1:0] dn_ang,
    output logic [KW-1:0]             dn_keep
);

    logic                      take;
    logic                      x_neg;
    logic                      y_neg;
    logic                      z_neg;
    logic                      zero_xy;
    logic                      z_pos;
    logic signed [DW-1:0]      x_ext;
    logic signed [DW-1:0]      y_ext;
    logic signed [DW-1:0]      x_fold;
    logic signed [DW-1:0]      y_fold;
    logic [CW-1:0]             z_mag;
    logic [PW-1:0]             z_prod;
    logic                      valid_reg;
    logic                      valid_next;
    logic signed [DW-1:0]      x_reg;
    logic signed [DW-1:0]      x_next;
    logic signed [DW-1:0]      y_reg;
    logic signed [DW-1:0]      y_next;
    logic signed [ANGLE_W-1:0] ang_reg;
    logic signed [ANGLE_W-1:0] ang_next;
    logic [KW-1:0]             keep_reg;
    logic [KW-1:0]             keep_next;

    assign take      = !valid_reg || dn_ready;
    assign vec.ready = take;

    always_comb
    begin
        x_neg   = vec.x_component[CW-1];
        y_neg   = vec.y_component[CW-1];
        z_neg   = vec.z_component[CW-1];
        zero_xy = (vec.x_component == '0) && (vec.y_component == '0);
        z_pos   = !z_neg && (vec.z_component != '0);
        x_ext   = {{(DW-CW){vec.x_component[CW-1]}}, vec.x_component};
        y_ext   = {{(DW-CW){vec.y_component[CW-1]}}, vec.y_component};
        // A vector in the left half plane is turned by a half turn first.
        x_fold  = x_neg ? -x_ext : x_ext;
        y_fold  = x_neg ? -y_ext : y_ext;
        x_next  = x_fold <<< GUARD_BITS;
        y_next  = y_fold <<< GUARD_BITS;
        if (!x_neg)
        begin
            ang_next = '0;
        end
        else if (y_neg)
        begin
            ang_next = -HALF_TURN;
        end
        else
        begin
            ang_next = HALF_TURN;
        end
        z_mag      = z_neg ? -vec.z_component : vec.z_component;
        z_prod     = {{GAIN_W{1'b0}}, z_mag} * {{CW{1'b0}}, GAIN_Q30};
        keep_next  = {zero_xy, z_pos, z_neg, z_prod};
        valid_next = take ? vec.valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && vec.valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            keep_reg <= keep_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_ang   = ang_reg;
    assign dn_keep  = keep_reg;

endmodule

// ===== rtl/v2py_join.sv =====
// Last yaw iteration plus setup of the pitch pass: planar length against gain-scaled z.
module v2py_join
    import v2py_pkg::*;
#(
    parameter int CW = 24,
    localparam int DW = CW + GUARD_BITS + DP_HEADROOM,
    localparam int PW = CW + GAIN_W,
    localparam int KY = PW + 3,
    localparam int KP = ANGLE_W + 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic signed [DW-1:0]      up_x,
    input  logic signed [DW-1:0]      up_y,
    input  logic signed [ANGLE_W-1:0] up_ang,
    input  logic [KY-1:0]             up_keep,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output logic signed [DW-1:0]      dn_x,
    output logic signed [DW-1:0]      dn_y,
    output logic [KP-1:0]             dn_keep
);

    localparam int LAST = CORDIC_STAGES - 1;
    localparam int RW   = PW + 1 - GAIN_SHIFT;

    logic                      take;
    logic                      rot_pos;
    logic signed [DW-1:0]      ys;
    logic signed [ANGLE_W-1:0] yaw_ang;
    logic [PW:0]               z_round;
    logic [DW-1:0]             z_unsigned;
    logic                      valid_reg;
    logic                      valid_next;
    logic signed [DW-1:0]      x_reg;
    logic signed [DW-1:0]      x_next;
    logic signed [DW-1:0]      y_reg;
    logic signed [DW-1:0]      y_next;
    logic [KP-1:0]             keep_reg;
    logic [KP-1:0]             keep_next;

    assign take     = !valid_reg || dn_ready;
    assign up_ready = take;

    always_comb
    begin
        ys      = up_y >>> LAST;
        rot_pos = !up_y[DW-1];
        if (rot_pos)
        begin
            x_next  = up_x + ys;
            yaw_ang = up_ang + ATAN_TAB[LAST];
        end
        else
        begin
            x_next  = up_x - ys;
            yaw_ang = up_ang - ATAN_TAB[LAST];
        end
        // Round the gain product half up on its magnitude, then restore the sign.
        z_round    = {1'b0, up_keep[PW-1:0]} + (PW+1)'(2 ** (GAIN_SHIFT - 1));
        z_unsigned = {{(DW-RW){1'b0}}, z_round[PW:GAIN_SHIFT]};
        y_next     = up_keep[PW] ? -z_unsigned : z_unsigned;
        keep_next  = {up_keep[PW+2], up_keep[PW+1], yaw_ang};
        valid_next = take ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            keep_reg <= keep_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_keep  = keep_reg;

endmodule

// ===== rtl/v2py_deg.sv =====
// Exit cell: last pitch iteration, degree truncation and wrap, output register.
`include "vector_to_pitch_yaw_unit_defines.svh"

module v2py_deg
    import v2py_pkg::*;
#(
    parameter int CW = 24,
    localparam int DW = CW + GUARD_BITS + DP_HEADROOM,
    localparam int KP = ANGLE_W + 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic signed [DW-1:0]      up_x,
    input  logic signed [DW-1:0]      up_y,
    input  logic signed [ANGLE_W-1:0] up_ang,
    input  logic [KP-1:0]             up_keep,
    v2py_ang_if.source                ang
);

    localparam int SW   = ANGLE_W + 1;
    localparam int QW   = SW - ANGLE_FRAC;
    localparam int LAST = CORDIC_STAGES - 1;
    localparam logic signed [SW-1:0] BIAS = SW'(TRUNC_BIAS);
    localparam logic signed [SW-1:0] TAIL = SW'(ATAN_TAB[LAST]);
    localparam logic signed [SW-1:0] BIAS_PLUS_TAIL  = BIAS + TAIL;
    localparam logic signed [SW-1:0] BIAS_MINUS_TAIL = BIAS - TAIL;

    function automatic logic [DEG_W-1:0] to_deg(input logic neg, input logic [SW-1:0] mag_b);
        logic [QW-1:0] d;
        logic [QW-1:0] r;
        d = mag_b[SW-1:ANGLE_FRAC];
        r = (neg && d != '0) ? QW'(DEG_360) - d : d;
        return r[DEG_W-1:0];
    endfunction

    logic                take;
    logic                rot_pos;
    logic                zero_xy;
    logic                z_pos;
    logic signed [SW-1:0] p_ext;
    logic signed [SW-1:0] p_fin;
    logic signed [SW-1:0] p_pos_sum;
    logic signed [SW-1:0] p_neg_sum;
    logic signed [SW-1:0] w_ext;
    logic signed [SW-1:0] w_pos_sum;
    logic signed [SW-1:0] w_neg_sum;
    logic                valid_reg;
    logic                valid_next;
    logic [DEG_W-1:0]    pitch_reg;
    logic [DEG_W-1:0]    pitch_next;
    logic [DEG_W-1:0]    yaw_reg;
    logic [DEG_W-1:0]    yaw_next;

    assign take     = !valid_reg || ang.ready;
    assign up_ready = take;

    always_comb
    begin
        rot_pos = !up_y[DW-1];
        zero_xy = up_keep[KP-1];
        z_pos   = up_keep[KP-2];
        p_ext   = {up_ang[ANGLE_W-1], up_ang};
        // The final pitch step is folded into the bias constants so the
        // magnitude-plus-bias sums do not wait for the step's own adder.
        p_fin     = rot_pos ? p_ext + TAIL : p_ext - TAIL;
        p_pos_sum = p_ext + (rot_pos ? BIAS_PLUS_TAIL : BIAS_MINUS_TAIL);
        p_neg_sum = (rot_pos ? BIAS_MINUS_TAIL : BIAS_PLUS_TAIL) - p_ext;
        w_ext     = {up_keep[ANGLE_W-1], up_keep[ANGLE_W-1:0]};
        w_pos_sum = w_ext + BIAS;
        w_neg_sum = BIAS - w_ext;
        if (zero_xy)
        begin
            pitch_next = z_pos ? DEG_90 : DEG_270;
            yaw_next   = '0;
        end
        else
        begin
            pitch_next = to_deg(p_fin[SW-1], p_fin[SW-1] ? p_neg_sum : p_pos_sum);
            yaw_next   = to_deg(w_ext[SW-1], w_ext[SW-1] ? w_neg_sum : w_pos_sum);
        end
        valid_next = take ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign ang.valid     = valid_reg;
    assign ang.pitch_deg = pitch_reg;
    assign ang.yaw_deg   = yaw_reg;

    `V2PY_ASSERT_IMP(a_len_sign, up_valid, !up_x[DW-1], "pitch pass length went negative")
    `V2PY_ASSERT_IMP(a_pitch_range, valid_reg, (pitch_reg <= DEG_90 || pitch_reg >= DEG_270) && pitch_reg <= DEG_359, "pitch out of range")
    `V2PY_ASSERT_IMP(a_yaw_range, valid_reg, yaw_reg <= DEG_359, "yaw out of range")
    `V2PY_ASSERT_NEXT(a_zero_vector, up_valid && take && zero_xy, yaw_reg == '0 && (pitch_reg == DEG_90 || pitch_reg == DEG_270), "zero planar vector gave a wrong result")

endmodule

// ===== bench/vector_to_pitch_yaw_unit_test.sv =====
// Self-checking bench for vector_to_pitch_yaw_unit: directed and random vectors with idling.
import v2py_pkg::*;

localparam int CW = 24;

// atan(2^-i) in degrees with 20 fractional bits.
localparam longint ATAN_STEP_DEG [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
};
localparam longint          PATH_SCALE   = 64'sd1 << 26;
localparam longint unsigned CORDIC_GAIN  = 64'd1768195363;
localparam longint          HALF_TURN_FX = 64'sd180 << 20;

class pitch_yaw_scoreboard;
    typedef struct {
        logic [DEG_W-1:0] pitch;
        logic [DEG_W-1:0] yaw;
    } angle_pair_t;

    angle_pair_t expected_angles[$];
    int mismatches = 0;

    // Vectoring CORDIC: drives cy toward zero and returns the accumulated angle.
    function longint rotate_to_axis(inout longint cx, inout longint cy, input longint ang);
        longint xs;
        longint ys;
        for (int i = 0; i < 24; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy >= 0)
            begin
                cx  = cx + ys;
                cy  = cy - xs;
                ang = ang + ATAN_STEP_DEG[i];
            end
            else
            begin
                cx  = cx - ys;
                cy  = cy + xs;
                ang = ang - ATAN_STEP_DEG[i];
            end
        end
        return ang;
    endfunction

    function logic [DEG_W-1:0] whole_degrees(longint ang);
        longint unsigned mag;
        longint unsigned deg;
        mag = (ang < 0) ? longint'(-ang) : longint'(ang);
        deg = (mag + 64'd128) >> 20;
        if (ang < 0 && deg != 0)
            deg = 64'd360 - deg;
        return deg[DEG_W-1:0];
    endfunction

    function angle_pair_t predict_angles(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                         logic signed [CW-1:0] z);
        longint xv;
        longint yv;
        longint zv;
        longint cx;
        longint cy;
        longint yaw_ang;
        longint pitch_ang;
        longint unsigned zmag;
        longint unsigned zprod;
        angle_pair_t r;
        xv = x;
        yv = y;
        zv = z;
        if (xv == 0 && yv == 0)
        begin
            r.pitch = (zv > 0) ? DEG_90 : DEG_270;
            r.yaw   = '0;
            return r;
        end
        // A vector in the left half plane is turned by half a turn first.
        if (xv < 0)
        begin
            cx = -xv * PATH_SCALE;
            cy = -yv * PATH_SCALE;
            yaw_ang = (yv >= 0) ? HALF_TURN_FX : -HALF_TURN_FX;
        end
        else
        begin
            cx = xv * PATH_SCALE;
            cy = yv * PATH_SCALE;
            yaw_ang = 0;
        end
        yaw_ang = rotate_to_axis(cx, cy, yaw_ang);
        // z gets the same CORDIC gain as the planar length.
        zmag  = (zv < 0) ? longint'(-zv) : longint'(zv);
        zprod = (zmag * CORDIC_GAIN + 64'd8) >> 4;
        cy = (zv < 0) ? -longint'(zprod) : longint'(zprod);
        pitch_ang = rotate_to_axis(cx, cy, 0);
        r.pitch = whole_degrees(pitch_ang);
        r.yaw   = whole_degrees(yaw_ang);
        return r;
    endfunction

    function void note_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] z);
        expected_angles.push_back(predict_angles(x, y, z));
    endfunction

    function void check_angles(logic [DEG_W-1:0] pitch, logic [DEG_W-1:0] yaw, realtime at_ns);
        angle_pair_t e;
        if (expected_angles.size() == 0)
        begin
            $display("%0.1f ns: unexpected result item pitch %0d yaw %0d", at_ns, pitch, yaw);
            mismatches++;
            return;
        end
        e = expected_angles.pop_front();
        if (pitch !== e.pitch)
        begin
            $display("%0.1f ns: pitch_deg expected %0d, got %0d", at_ns, e.pitch, pitch);
            mismatches++;
        end
        if (yaw !== e.yaw)
        begin
            $display("%0.1f ns: yaw_deg expected %0d, got %0d", at_ns, e.yaw, yaw);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_angles.size();
    endfunction
endclass

module vector_to_pitch_yaw_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n;
    bit   no_idle = 1'b0;

    v2py_vec_if #(.WIDTH(CW)) vec_ch ();
    v2py_ang_if               ang_ch ();

    pitch_yaw_scoreboard angle_board = new();

    vector_to_pitch_yaw_unit #(.COMPONENT_WIDTH(CW)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vec   (vec_ch),
        .ang   (ang_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #8ms;
        $display("vector_to_pitch_yaw_unit: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && ang_ch.valid && ang_ch.ready)
            angle_board.check_angles(ang_ch.pitch_deg, ang_ch.yaw_deg, $realtime);
    end

    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Result side: ready toggles with short and occasional long stalls.
    initial
    begin
        int stall_left;
        int roll;
        stall_left = 0;
        ang_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (no_idle)
                ang_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                ang_ch.ready <= 1'b0;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    ang_ch.ready <= 1'b1;
                else if (roll < 95)
                begin
                    ang_ch.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end
                else
                begin
                    ang_ch.ready <= 1'b0;
                    stall_left = $urandom_range(5, 40);
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic signed [CW-1:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            vec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_ch.valid       <= 1'b1;
        vec_ch.x_component <= x;
        vec_ch.y_component <= y;
        vec_ch.z_component <= z;
        do
            @(posedge clk);
        while (!vec_ch.ready);
        angle_board.note_vector(x, y, z);
    endtask

    task automatic wait_for_results();
        vec_ch.valid <= 1'b0;
        @(posedge clk);
        while (angle_board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] pick_component();
        logic signed [CW-1:0] v;
        int roll;
        roll = $urandom_range(0, 99);
        v = CW'($urandom);
        if (roll < 15)
            v = CW'(int'($urandom_range(0, 32)) - 16);
        else if (roll < 25)
        begin
            case ($urandom_range(0, 4))
                0: v = CMAX;
                1: v = CMIN;
                2: v = '0;
                3: v = '1;
                default: v = CW'(1);
            endcase
        end
        else if (roll < 45)
            v = v >>> $urandom_range(1, 22);
        return v;
    endfunction

    task automatic send_random_vectors(int count);
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        int roll;
        for (int n = 0; n < count; n++)
        begin
            x = pick_component();
            y = pick_component();
            z = pick_component();
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                x = '0;
                y = '0;
            end
            else if (roll < 8)
                y = x;
            else if (roll < 11)
                y = -x;
            else if (roll < 13)
                z = x;
            send_vector(x, y, z);
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        vec_ch.valid       <= 1'b0;
        vec_ch.x_component <= '0;
        vec_ch.y_component <= '0;
        vec_ch.z_component <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero planar length, with z positive, zero and negative.
        send_vector('0, '0, '0);
        send_vector('0, '0, CW'(1));
        send_vector('0, '0, CW'(-1));
        send_vector('0, '0, CMAX);
        send_vector('0, '0, CMIN);
        // Axes and diagonals, where exact angles must not drop a degree.
        send_vector(CW'(1), '0, '0);
        send_vector('0, CW'(5), '0);
        send_vector('0, CW'(-5), '0);
        send_vector(CW'(-7), '0, '0);
        send_vector(CW'(-7), CW'(-1), '0);
        send_vector(CW'(1000), CW'(1000), '0);
        send_vector(CW'(1000), CW'(-1000), '0);
        send_vector(CW'(-1000), CW'(1000), '0);
        send_vector(CW'(-1000), CW'(-1000), '0);
        send_vector(CW'(3), CW'(4), CW'(5));
        send_vector(CW'(3), '0, CW'(-3));
        // Tiny negative angles truncate to zero rather than wrap to 360.
        send_vector(CMAX, CW'(-1), CW'(-1));
        send_vector(CMAX, CW'(1), CW'(1));
        // Extremes of all three components.
        send_vector(CMAX, CMAX, CMAX);
        send_vector(CMIN, CMIN, CMIN);
        send_vector(CMIN, CMAX, CMIN);
        send_vector(CMAX, CMIN, CMAX);
        send_vector(CMIN, '0, CMAX);
        send_vector(CW'(1), CMIN, '0);

        send_random_vectors(600);
        wait_for_results();
        no_idle = 1'b1;
        send_random_vectors(250);
        no_idle = 1'b0;
        send_random_vectors(700);

        wait_for_results();
        repeat (60) @(posedge clk);
        if (angle_board.pending() != 0)
        begin
            $display("%0.1f ns: %0d expected result items never arrived", $realtime,
                     angle_board.pending());
            angle_board.mismatches++;
        end
        if (angle_board.mismatches == 0)
            $display("vector_to_pitch_yaw_unit: match");
        else
            $display("vector_to_pitch_yaw_unit: mismatch");
        $finish;
    end
endmodule
